[design/uartfc_pkg.sv]
// Shared types and constants for the UART receive FIFO with RTS/CTS flow control.
package uartfc_pkg;

    localparam int unsigned CFG_W  = 6;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [2:0] {
        KIND_RX      = 3'd0,
        KIND_POP     = 3'd1,
        KIND_SEND    = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_RETRY   = 3'd4,
        KIND_TXDONE  = 3'd5
    } t_kind;

    typedef enum logic {
        CFG_CTS_ASSERT_FREE   = 1'b0,
        CFG_CTS_RELEASE_LEVEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_ring_ctl;

    typedef struct packed {
        logic              send;
        logic              release_evt;
        logic              retry;
        logic [BYTE_W-1:0] data;
        logic              rts;
        logic              txe;
    } t_tx_req;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_status;
    } t_tx_res;

    // Field order from the most significant bit down to bit zero.
    typedef struct packed {
        logic [3:0]        pad;
        logic              overflow;
        logic [5:0]        rx_count;
        logic              sent_done;
        logic              send_status;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              cts_level;
        logic [BYTE_W-1:0] deliver_byte;
        logic              deliver_valid;
    } t_result;

endpackage

[design/uart_rx_fifo_flow_control_unit.sv]
// Top level of the UART receive FIFO with RTS/CTS flow control and held-byte transmit.
//
//  Channel   Direction  Ports                          Content
//  s         in         i_s_tvalid/o_s_tready          event: kind, byte, RTS pin, TX empty
//  m         out        o_m_tvalid/i_m_tready          result of one event
//  cfg       in         i_cfg_we/i_cfg_idx/i_cfg_data  CTS thresholds
//
// Every event completes in the cycle it is accepted; its result is registered and
// shown on the master side; one event per cycle is sustained while results are taken.
// A two-entry result buffer (output register plus skid register) decouples the
// sides: the slave side stalls only while both entries are full.
// Reset is synchronous and active low; it empties the queue and the result buffer.
module uart_rx_fifo_flow_control_unit
    import uartfc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] data_byte, [8] rts_level, [9] tx_reg_empty, [15:10] zero
    input  logic [15:0] i_s_tdata,
    // [2:0] kind
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] deliver_valid, [8:1] deliver_byte, [9] cts_level, [10] tx_valid,
    // [18:11] tx_byte, [19] send_status, [20] sent_done, [26:21] rx_count,
    // [27] overflow, [31:28] zero
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic              w_acc;
    logic              w_pop_out;
    t_kind             w_kind;
    logic [BYTE_W-1:0] w_byte;
    t_ring_ctl         w_ring_ctl;
    t_tx_req           w_tx_req;
    t_tx_res           w_tx_res;
    logic [BYTE_W-1:0] w_head;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_count_next;
    logic              w_full;
    logic              w_empty;
    t_result           w_res;

    logic [CFG_W-1:0]  r_cts_assert;
    logic [CFG_W-1:0]  r_cts_release;
    logic              r_cts;
    logic              n_cts;
    t_result           r_head;
    logic              r_head_v;
    t_result           r_skid;
    logic              r_skid_v;

    assign o_s_tready = !r_skid_v;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_pop_out  = r_head_v && i_m_tready;
    assign w_kind     = t_kind'(i_s_tuser);
    assign w_byte     = i_s_tdata[7:0];
    assign w_full     = (w_count == CNT_W'(RING_DEPTH));
    assign w_empty    = (w_count == '0);

    always_comb begin
        w_ring_ctl      = '0;
        w_ring_ctl.data = w_byte;
        w_tx_req        = '0;
        w_tx_req.data   = w_byte;
        w_tx_req.rts    = i_s_tdata[8];
        w_tx_req.txe    = i_s_tdata[9];
        if (w_acc) begin
            case (w_kind)
                KIND_RX:      w_ring_ctl.push      = 1'b1;
                KIND_POP:     w_ring_ctl.pop       = 1'b1;
                KIND_SEND:    w_tx_req.send        = 1'b1;
                KIND_RELEASE: w_tx_req.release_evt = 1'b1;
                KIND_RETRY:   w_tx_req.retry       = 1'b1;
                default:      ;
            endcase
        end
    end

    always_comb begin
        w_count_next = w_count;
        n_cts        = r_cts;
        if (w_ring_ctl.push) begin
            if (!w_full) begin
                w_count_next = w_count + 1'b1;
            end
            if ((CMP_W'(RING_DEPTH) - CMP_W'(w_count_next)) < CMP_W'(r_cts_assert)) begin
                n_cts = 1'b1;
            end
        end else if (w_ring_ctl.pop && !w_empty) begin
            w_count_next = w_count - 1'b1;
            if (CMP_W'(w_count) < CMP_W'(r_cts_release)) begin
                n_cts = 1'b0;
            end
        end
    end

    always_comb begin
        w_res               = '0;
        w_res.deliver_valid = w_ring_ctl.pop && !w_empty;
        w_res.deliver_byte  = w_res.deliver_valid ? w_head : '0;
        w_res.cts_level     = n_cts;
        w_res.tx_valid      = w_tx_res.tx_valid;
        w_res.tx_byte       = w_tx_res.tx_byte;
        w_res.send_status   = w_tx_res.send_status;
        w_res.sent_done     = (w_kind == KIND_TXDONE);
        w_res.rx_count      = 6'(w_count_next);
        w_res.overflow      = w_ring_ctl.push && w_full;
    end

    uartfc_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .o_head  (w_head),
        .o_count (w_count)
    );

    uartfc_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tx_req),
        .o_res   (w_tx_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cts_assert  <= CFG_W'(5);
            r_cts_release <= CFG_W'(16);
            r_cts         <= 1'b0;
        end else begin
            r_cts <= n_cts;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CTS_ASSERT_FREE:   r_cts_assert  <= i_cfg_data;
                    CFG_CTS_RELEASE_LEVEL: r_cts_release <= i_cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_pop_out) begin
                if (r_skid_v) begin
                    r_head_v <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_head_v <= w_acc;
                end
            end else if (w_acc) begin
                if (r_head_v) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_head_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_out) begin
            r_head <= r_skid_v ? r_skid : w_res;
        end else if (w_acc) begin
            if (r_head_v) begin
                r_skid <= w_res;
            end else begin
                r_head <= w_res;
            end
        end
    end

    assign o_m_tvalid = r_head_v;
    assign o_m_tdata  = r_head;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("Skid register holds a result while the output register is empty.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(RING_DEPTH))
        else $error("Receive queue count exceeds its depth.");

    a_full_stays_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ring_ctl.push && w_full) |=> w_full)
        else $error("A dropped byte changed the receive queue count.");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_v && !i_m_tready) |=> r_head_v)
        else $error("An untaken result was lost from the output register.");

endmodule

[design/uartfc_cell.sv]
// One storage cell of the receive chain: holds a byte and shifts towards the head on a pop.
module uartfc_cell
    import uartfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_pop,
    input  logic              i_load,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_next,
    output logic [BYTE_W-1:0] o_data
);

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_pop) begin
            n_data = i_next;
        end else if (i_load) begin
            n_data = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[design/uartfc_ring.sv]
// Receive queue built as a chain of cells with the oldest byte always in the first cell.
module uartfc_ring
    import uartfc_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_ctl         i_ctl,
    output logic [BYTE_W-1:0] o_head,
    output logic [CNT_W-1:0]  o_count
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_push;
    logic              w_pop;
    logic [BYTE_W-1:0] w_data [DEPTH];
    logic [BYTE_W-1:0] w_next [DEPTH];

    assign w_push = i_ctl.push && (r_count != CNT_W'(DEPTH));
    assign w_pop  = i_ctl.pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + 1'b1;
        end else if (w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = w_data[g];
        end else begin : g_mid
            assign w_next[g] = w_data[g+1];
        end
        uartfc_cell u_cell (
            .i_clk  (i_clk),
            .i_pop  (w_pop),
            .i_load (w_push && (r_count == CNT_W'(g))),
            .i_byte (i_ctl.data),
            .i_next (w_next[g]),
            .o_data (w_data[g])
        );
    end

    assign o_head  = w_data[0];
    assign o_count = r_count;

endmodule

[design/uartfc_tx.sv]
// Transmit side: send gating on release, partner RTS and transmitter empty, with a held byte.
module uartfc_tx
    import uartfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_tx_req i_req,
    output t_tx_res o_res
);

    logic              r_released;
    logic              n_released;
    logic              r_pending;
    logic              n_pending;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;
    logic              w_attempt;
    logic              w_ok;

    always_comb begin
        n_released = r_released || i_req.release_evt;
        n_byte     = i_req.send ? i_req.data : r_byte;
        w_attempt  = i_req.send || ((i_req.release_evt || i_req.retry) && r_pending);
        w_ok       = n_released && !i_req.rts && i_req.txe;
        n_pending  = r_pending;
        o_res      = '0;
        if (w_attempt) begin
            n_pending         = !w_ok;
            o_res.send_status = !w_ok;
            o_res.tx_valid    = w_ok;
            o_res.tx_byte     = w_ok ? n_byte : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_released <= 1'b0;
            r_pending  <= 1'b0;
            r_byte     <= '0;
        end else begin
            r_released <= n_released;
            r_pending  <= n_pending;
            r_byte     <= n_byte;
        end
    end

endmodule
